>>> src/htcb_pkg.sv
// Shared types and constants for the head and tail capture buffer
package htcb_pkg;

  // retention limit register
  localparam int unsigned LIMIT_W     = 11;
  localparam int unsigned LIMIT_RESET = 1024;

  // total byte counter
  localparam int unsigned TOTAL_W = 64;

  // operation codes
  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_DRAIN  = 1'b1
  } op_t;

  // per-item control carried from the issue stage to the result register
  typedef struct packed {
    logic is_byte;     // a stored byte was read for this item
    logic sel_head;    // byte comes from the head store, else the tail ring
    logic drain_last;  // this item cleared the capture
    logic status;      // append refused, total at its maximum
  } item_info_t;

endpackage

>>> src/head_tail_capture_buffer.sv
// Top level of the head and tail capture buffer
//
// Usage:
//   Input channel (in_valid / in_ready) carries one operation per transfer:
//   append one byte (data_byte) or drain one retained byte. chunk_end is
//   informational and has no effect. Every input transfer gives exactly one
//   result transfer on result_valid / result_ready.
//   Out of retention_limit bytes (saturated at MAX_RETAIN), the first half
//   rounded up is kept in the head store and the latest half rounded down in
//   a tail ring that overwrites its oldest byte. Drains return head bytes
//   first, then tail bytes oldest to newest; the last one clears the capture.
//   Each item passes the issue stage (state update and store read) and then
//   the result register. Throughput: one item per cycle when not stalled;
//   both stores are dual port RAMs written on append and read on drain, so
//   appends and drains may follow back to back. When the receiver stalls,
//   one result waits in the result register and one item in the issue
//   stage; in_ready then drops until the result moves.
//   Reset (rst, synchronous) clears all capture state and sets the limit to
//   1024; store contents are not cleared and need no clearing pass.
//   cfg_wr_en writes the limit and clears the capture; use it only when idle.
module head_tail_capture_buffer
  import htcb_pkg::*;
#(
  parameter int unsigned MAX_RETAIN = 1024
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [LIMIT_W-1:0]  cfg_wr_data,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                operation,
  input  logic [7:0]          data_byte,
  input  logic                chunk_end,
  // result channel
  output logic                result_valid,
  input  logic                result_ready,
  output logic [7:0]          out_byte,
  output logic                out_valid,
  output logic                drain_last,
  output logic [TOTAL_W-1:0]  total_count,
  output logic                truncated,
  output logic                status
);

  localparam int unsigned HEAD_DEPTH = (MAX_RETAIN + 1) / 2;
  localparam int unsigned TAIL_DEPTH = MAX_RETAIN / 2;
  localparam int unsigned HAW = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
  localparam int unsigned TAW = (TAIL_DEPTH > 1) ? $clog2(TAIL_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(MAX_RETAIN + 1);
  localparam int unsigned EW  = (CW > LIMIT_W) ? CW : LIMIT_W;

  // capture state
  logic [LIMIT_W-1:0] limit;
  logic [CW-1:0]      head_count, head_count_next;
  logic [CW-1:0]      tail_count, tail_count_next;
  logic [TAW-1:0]     tail_ptr, tail_ptr_next;
  logic [TOTAL_W-1:0] byte_total, byte_total_next;
  logic [CW-1:0]      drain_pos, drain_pos_next;

  // issue stage
  logic               s1_valid;
  item_info_t         s1_info;
  logic [TOTAL_W-1:0] s1_total;
  logic [CW-1:0]      s1_retained;

  // combinational issue results
  item_info_t         info_next;
  logic [TOTAL_W-1:0] total_out;
  logic [CW-1:0]      retained_out;

  // store ports
  logic               head_we, head_re, tail_we, tail_re;
  logic [HAW-1:0]     head_waddr, head_raddr;
  logic [TAW-1:0]     tail_waddr, tail_raddr;
  logic [7:0]         head_rdata, tail_rdata;

  // limit split
  logic [EW-1:0]      limit_wide;
  logic [CW-1:0]      eff_limit, head_lim, tail_lim;
  logic [CW-1:0]      retained_cur;
  logic [CW-1:0]      tail_off;
  logic [CW:0]        tail_sum;
  logic [CW:0]        tail_idx;

  logic               in_xfer, out_load;

  assign limit_wide = EW'(limit);
  assign eff_limit  = (limit_wide > EW'(MAX_RETAIN)) ? CW'(MAX_RETAIN) : CW'(limit_wide);
  assign head_lim   = eff_limit - (eff_limit >> 1);
  assign tail_lim   = eff_limit >> 1;
  assign retained_cur = head_count + tail_count;

  // handshake: result register frees when empty or taken
  assign out_load = s1_valid && (!result_valid || result_ready);
  assign in_ready = !s1_valid || out_load;
  assign in_xfer  = in_valid && in_ready;

  // tail read index for a drain, oldest pointer plus offset wrapped once
  assign tail_off = drain_pos - head_count;
  assign tail_sum = (CW + 1)'(tail_ptr) + {1'b0, tail_off};
  assign tail_idx = (tail_sum >= {1'b0, tail_lim}) ? tail_sum - {1'b0, tail_lim} : tail_sum;

  // next capture state and store accesses for the offered item
  always_comb begin
    head_count_next = head_count;
    tail_count_next = tail_count;
    tail_ptr_next   = tail_ptr;
    byte_total_next = byte_total;
    drain_pos_next  = drain_pos;
    info_next       = '0;
    total_out       = byte_total;
    retained_out    = retained_cur;
    head_we         = 1'b0;
    head_waddr      = head_count[HAW-1:0];
    head_re         = 1'b0;
    head_raddr      = drain_pos[HAW-1:0];
    tail_we         = 1'b0;
    tail_waddr      = tail_ptr;
    tail_re         = 1'b0;
    tail_raddr      = tail_idx[TAW-1:0];
    if (op_t'(operation) == OP_APPEND) begin
      if (&byte_total) begin
        info_next.status = 1'b1;
      end else begin
        if (head_count < head_lim) begin
          head_we         = in_xfer;
          head_count_next = head_count + 1'b1;
        end else if (tail_lim != '0) begin
          tail_we = in_xfer;
          if (tail_count < tail_lim) begin
            tail_waddr      = tail_count[TAW-1:0];
            tail_count_next = tail_count + 1'b1;
          end else if ((CW'(tail_ptr) + 1'b1) == tail_lim) begin
            tail_ptr_next = '0;
          end else begin
            tail_ptr_next = tail_ptr + 1'b1;
          end
        end
        byte_total_next = byte_total + 1'b1;
      end
      total_out    = byte_total_next;
      retained_out = head_count_next + tail_count_next;
    end else begin
      if (retained_cur == '0 || drain_pos >= retained_cur) begin
        info_next.drain_last = 1'b1;
      end else begin
        info_next.is_byte = 1'b1;
        if (drain_pos < head_count) begin
          info_next.sel_head = 1'b1;
          head_re            = in_xfer;
        end else begin
          tail_re = in_xfer;
        end
        drain_pos_next = drain_pos + 1'b1;
        if (drain_pos_next >= retained_cur) begin
          info_next.drain_last = 1'b1;
        end
      end
      // a drain that ends the capture clears everything
      if (info_next.drain_last) begin
        head_count_next = '0;
        tail_count_next = '0;
        tail_ptr_next   = '0;
        byte_total_next = '0;
        drain_pos_next  = '0;
      end
    end
  end

  // capture state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= LIMIT_W'(LIMIT_RESET);
      head_count <= '0;
      tail_count <= '0;
      tail_ptr   <= '0;
      byte_total <= '0;
      drain_pos  <= '0;
    end else if (cfg_wr_en) begin
      limit      <= cfg_wr_data;
      head_count <= '0;
      tail_count <= '0;
      tail_ptr   <= '0;
      byte_total <= '0;
      drain_pos  <= '0;
    end else if (in_xfer) begin
      head_count <= head_count_next;
      tail_count <= tail_count_next;
      tail_ptr   <= tail_ptr_next;
      byte_total <= byte_total_next;
      drain_pos  <= drain_pos_next;
    end
  end

  // issue stage, waits here with the store read data while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_info     <= info_next;
      s1_total    <= total_out;
      s1_retained <= retained_out;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (s1_info.is_byte) begin
        out_byte <= s1_info.sel_head ? head_rdata : tail_rdata;
      end else begin
        out_byte <= '0;
      end
      out_valid   <= s1_info.is_byte;
      drain_last  <= s1_info.drain_last;
      total_count <= s1_total;
      truncated   <= (s1_total > TOTAL_W'(s1_retained));
      status      <= s1_info.status;
    end
  end

  // head store, first bytes of the stream
  htcb_ram #(
    .WIDTH (8),
    .DEPTH (HEAD_DEPTH)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (data_byte),
    .re    (head_re),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  // tail ring, latest bytes of the stream
  htcb_ram #(
    .WIDTH (8),
    .DEPTH (TAIL_DEPTH)
  ) u_tail_ram (
    .clk   (clk),
    .we    (tail_we),
    .waddr (tail_waddr),
    .wdata (data_byte),
    .re    (tail_re),
    .raddr (tail_raddr),
    .rdata (tail_rdata)
  );

`ifndef SYNTHESIS
  // head never holds more than its share of the limit
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head_count <= head_lim)
    else $error("head count above head share");

  // tail bytes only appear once the head is full
  a_tail_after_head: assert property (@(posedge clk) disable iff (rst)
    (tail_count != '0) |-> (head_count == head_lim && tail_count <= tail_lim))
    else $error("tail filled before head full or beyond its share");

  // oldest pointer only moves inside a full ring
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (tail_ptr != '0) |-> (tail_count == tail_lim && CW'(tail_ptr) < tail_lim))
    else $error("tail pointer out of range");

  // drain position stays inside the retained bytes
  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    (drain_pos != '0) |-> (drain_pos < retained_cur))
    else $error("drain position beyond retained bytes");

  // input stalls only when both stages are full and the result is not taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && result_valid && !result_ready))
    else $error("input stalled with room in the pipeline");

  // a drained byte never comes with a refused append
  a_byte_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(out_valid && status))
    else $error("drained byte flagged as refused append");
`endif

endmodule

>>> src/htcb_ram.sv
// Generic single write port, single read port RAM with registered read
module htcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/head_tail_capture_buffer_tb.sv
// Self-checking testbench for the head and tail capture buffer
`timescale 1ns / 1ps

module head_tail_capture_buffer_tb;
  import htcb_pkg::*;

  localparam int unsigned MAX_RETAIN  = 1024;
  localparam int unsigned HEAD_SLOTS  = (MAX_RETAIN + 1) / 2;
  localparam int unsigned TAIL_SLOTS  = MAX_RETAIN / 2;
  localparam int unsigned STALL_LEN   = 300;
  localparam int unsigned WATCHDOG    = 3000;
  localparam int unsigned SETTLE_WAIT = 4;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       chunk_end;
  } capture_op_t;

  typedef struct packed {
    logic [7:0]         data;
    logic               valid;
    logic               last;
    logic [TOTAL_W-1:0] total;
    logic               trunc;
    logic               status;
  } capture_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = 1'b0;
  logic [7:0]         data_byte = '0;
  logic               chunk_end = 1'b0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic [7:0]         out_byte;
  logic               out_valid;
  logic               drain_last;
  logic [TOTAL_W-1:0] total_count;
  logic               truncated;
  logic               status;

  // stimulus and expectation queues
  capture_op_t     ops_to_send[$];
  capture_result_t due_results[$];
  int unsigned     ops_queued = 0;
  int unsigned     failures = 0;

  // idling control, set per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          stall_request = 1'b0;
  bit          stall_taken = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  // predictor copy of the capture state
  logic [7:0]         head_copy [HEAD_SLOTS];
  logic [7:0]         tail_copy [TAIL_SLOTS];
  int unsigned        head_n = 0;
  int unsigned        tail_n = 0;
  int unsigned        tail_old = 0;
  int unsigned        drain_pos = 0;
  logic [TOTAL_W-1:0] total_copy = '0;
  int unsigned        limit_copy = LIMIT_RESET;

  head_tail_capture_buffer #(
    .MAX_RETAIN(MAX_RETAIN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .data_byte(data_byte),
    .chunk_end(chunk_end),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .out_byte(out_byte),
    .out_valid(out_valid),
    .drain_last(drain_last),
    .total_count(total_count),
    .truncated(truncated),
    .status(status)
  );

  always #6 clk = ~clk;

  task automatic clear_capture_copy();
    head_n = 0;
    tail_n = 0;
    tail_old = 0;
    drain_pos = 0;
    total_copy = '0;
  endtask

  // expected result of one accepted operation, state updated in step
  task automatic predict_capture_result(input op_t op, input logic [7:0] b);
    capture_result_t r;
    int unsigned lim, head_lim, tail_lim, kept, idx;
    lim = (limit_copy > MAX_RETAIN) ? MAX_RETAIN : limit_copy;
    head_lim = (lim + 1) / 2;
    tail_lim = lim / 2;
    r = '0;
    if (op == OP_APPEND) begin
      if (total_copy == {TOTAL_W{1'b1}}) begin
        r.status = 1'b1;
      end else begin
        if (head_n < head_lim && head_n < HEAD_SLOTS) begin
          head_copy[head_n] = b;
          head_n++;
        end else if (tail_lim > 0 && tail_lim <= TAIL_SLOTS) begin
          // fill the ring, then once it is full overwrite the oldest byte
          if (tail_n < tail_lim) begin
            tail_copy[tail_n] = b;
            tail_n++;
          end else begin
            tail_copy[tail_old % tail_lim] = b;
            tail_old = (tail_old % tail_lim + 1) % tail_lim;
          end
        end
        total_copy++;
      end
      kept = head_n + tail_n;
      r.total = total_copy;
      r.trunc = (total_copy > kept);
    end else begin
      kept = head_n + tail_n;
      r.total = total_copy;
      r.trunc = (total_copy > kept);
      if (kept == 0 || drain_pos >= kept) begin
        r.last = 1'b1;
        clear_capture_copy();
      end else begin
        // head bytes first, then tail from oldest to newest
        if (drain_pos < head_n) begin
          r.data = head_copy[drain_pos];
        end else begin
          idx = (tail_lim > 0) ? (tail_old + drain_pos - head_n) % tail_lim : 0;
          r.data = tail_copy[idx];
        end
        r.valid = 1'b1;
        drain_pos++;
        if (drain_pos >= kept) begin
          r.last = 1'b1;
          clear_capture_copy();
        end
      end
    end
    due_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  // input driver: one transfer per accepted item
  always @(posedge clk) begin : input_driver
    capture_op_t next_op;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_capture_result(op_t'(operation), data_byte);
      end
      if (!in_valid || in_ready) begin
        if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_op = ops_to_send.pop_front();
          in_valid <= 1'b1;
          operation <= next_op.op;
          data_byte <= next_op.data;
          chunk_end <= next_op.chunk_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin : result_monitor
    capture_result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual byte %0h total %0h",
                   $time, out_byte, total_count);
          failures++;
        end else begin
          want = due_results.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_valid", want.valid, out_valid);
          check_field("drain_last", want.last, drain_last);
          check_field("total_count", want.total, total_count);
          check_field("truncated", want.trunc, truncated);
          check_field("status", want.status, status);
        end
      end
      // long hold-off so the block fills and stalls its input
      if (stall_request && !stall_taken) begin
        stall_taken = 1'b1;
        stall_left = STALL_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (result_valid && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("head_tail_capture_buffer regression: fail");
        $finish;
      end
    end
  end

  task automatic add_op(input op_t op, input logic [7:0] b, input logic ce);
    capture_op_t item;
    item.op = op;
    item.data = b;
    item.chunk_end = ce;
    ops_to_send.push_back(item);
    ops_queued++;
  endtask

  // wait until every queued item has been transferred and answered
  task automatic wait_idle();
    while (ops_to_send.size() != 0 || in_valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    limit_copy = v;
    clear_capture_copy();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one capture round: a run of appends then a drain of what is kept,
  // sometimes with appends mixed into the drain, sometimes plain noise
  task automatic queue_capture_round(input int unsigned lim, input int unsigned max_run,
                                     input int unsigned forced_run);
    int unsigned n, head_lim, kept, drains;
    if (forced_run == 0 && $urandom_range(99) < 15) begin
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++) begin
        add_op(op_t'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end else begin
      n = (forced_run != 0) ? forced_run : $urandom_range(max_run);
      for (int i = 0; i < n; i++) begin
        add_op(OP_APPEND, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      head_lim = (lim + 1) / 2;
      if (n <= head_lim) begin
        kept = n;
      end else begin
        kept = head_lim + ((n - head_lim < lim / 2) ? n - head_lim : lim / 2);
      end
      drains = kept + $urandom_range(1);
      for (int i = 0; i < drains; i++) begin
        if ($urandom_range(7) == 0) begin
          add_op(OP_APPEND, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        add_op(OP_DRAIN, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim_val, input int unsigned budget,
                           input int unsigned s_pct, input int unsigned r_pct,
                           input bit big_run, input bit hold);
    int unsigned eff, first, max_run;
    write_limit(lim_val);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stall_request = hold;
    eff = (lim_val > MAX_RETAIN) ? MAX_RETAIN : lim_val;
    max_run = (2 * eff + 3 < 80) ? 2 * eff + 3 : 40;
    first = ops_queued;
    // one run past the head store so the tail ring starts to fill
    if (big_run) queue_capture_round(eff, max_run, eff / 2 + 3);
    while (ops_queued - first < budget) queue_capture_round(eff, max_run, 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 75;

    // reset limit: byte extremes, drain, append mid-drain, drain to the end
    add_op(OP_APPEND, 8'h00, 1'b0);
    add_op(OP_APPEND, 8'hFF, 1'b1);
    add_op(OP_APPEND, 8'h5A, 1'b0);
    add_op(OP_APPEND, 8'hA5, 1'b1);
    add_op(OP_APPEND, 8'h01, 1'b0);
    add_op(OP_APPEND, 8'h80, 1'b1);
    add_op(OP_DRAIN, 8'h00, 1'b0);
    add_op(OP_DRAIN, 8'hFF, 1'b1);
    add_op(OP_APPEND, 8'h3C, 1'b1);
    repeat (5) add_op(OP_DRAIN, 8'h00, 1'b0);

    // tiny limit: tail ring wraps, bytes are truncated
    write_limit(11'd3);
    add_op(OP_APPEND, 8'h11, 1'b0);
    add_op(OP_APPEND, 8'h22, 1'b0);
    add_op(OP_APPEND, 8'h33, 1'b0);
    add_op(OP_APPEND, 8'h44, 1'b0);
    add_op(OP_APPEND, 8'h55, 1'b1);
    repeat (3) add_op(OP_DRAIN, 8'h00, 1'b0);
    // left retained so that the next register write must clear it
    add_op(OP_APPEND, 8'h66, 1'b1);

    // zero limit: nothing kept, drain is empty but truncated
    write_limit(11'd0);
    add_op(OP_APPEND, 8'h77, 1'b1);
    add_op(OP_DRAIN, 8'h00, 1'b0);

    // random phases: sender idles less, then receiver, then neither
    run_phase(11'd1, 50, 36, 75, 1'b0, 1'b0);
    run_phase(11'd2, 60, 36, 75, 1'b0, 1'b0);
    run_phase(11'd7, 60, 75, 36, 1'b0, 1'b0);
    // above the maximum, the limit saturates
    run_phase(11'd2047, 100, 75, 36, 1'b1, 1'b0);
    run_phase(11'd33, 60, 75, 36, 1'b0, 1'b0);
    run_phase(11'd1024, 80, 0, 0, 1'b0, 1'b1);
    run_phase(11'd0, 30, 0, 0, 1'b0, 1'b0);
    run_phase(11'd1023, 60, 0, 0, 1'b0, 1'b0);

    wait_idle();
    if (failures == 0) begin
      $display("head_tail_capture_buffer regression: pass");
    end else begin
      $display("head_tail_capture_buffer regression: fail");
    end
    $finish;
  end

endmodule
